// File: rtl/core/vote_group_hysteresis_detector_assert.svh
`ifndef VOTE_GROUP_HYSTERESIS_DETECTOR_ASSERT_SVH
`define VOTE_GROUP_HYSTERESIS_DETECTOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VGHD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define VGHD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/vghd_pkg.sv
package vghd_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} vghd_state_t;

	typedef enum logic [1:0] {
		CFG_JAM_THRESHOLD    = 2'd0,
		CFG_GROUP_SIZE       = 2'd1,
		CFG_JAM_VOTE_MINIMUM = 2'd2,
		CFG_SWITCH_GROUPS    = 2'd3
	} vghd_cfg_idx_t;

	localparam int unsigned SCORE_W  = 8;
	localparam int unsigned THR_W    = 8;
	localparam int unsigned SIZE_W   = 5;
	localparam int unsigned VMIN_W   = 5;
	localparam int unsigned SWITCH_W = 4;
	localparam int unsigned VOTE_W   = 5;
	localparam int unsigned MEAN_W   = 8;
	localparam int unsigned DEC_W    = 32;
	localparam int unsigned CFG_W    = 8;
	localparam int unsigned OUT_W    = 56;

	localparam logic [THR_W-1:0]    RST_JAM_THRESHOLD    = 8'd223;
	localparam logic [SIZE_W-1:0]   RST_GROUP_SIZE       = 5'd5;
	localparam logic [VMIN_W-1:0]   RST_JAM_VOTE_MINIMUM = 5'd4;
	localparam logic [SWITCH_W-1:0] RST_SWITCH_GROUPS    = 4'd2;

	localparam logic [SWITCH_W-1:0] STREAK_MAX = 4'd15;
	localparam logic [MEAN_W-1:0]   MEAN_MAX   = 8'd255;

endpackage

// File: rtl/core/vote_group_hysteresis_detector.sv
// channel  dir  handshake                 payload
// s_       in   s_tvalid / s_tready       s_tdata: score
// m_       out  m_tvalid / m_tready       m_tdata: one group decision
// cfg_     in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A score that does not close a group is taken in ST_IDLE and updates the counters.
// A score that closes a group runs N = 9 + clog2(MAX_GROUP+1) steps of the
// restoring divider for the rounded mean; no scores are taken until ST_FIN loads m_.
// Reset loads the register defaults and clears all counters; no clearing pass.
// A stalled m_ side holds the finished decision; scores are still taken meanwhile
// until the next group closes.
`include "vote_group_hysteresis_detector_assert.svh"

module vote_group_hysteresis_detector import vghd_pkg::*; #(
	parameter int unsigned MAX_GROUP = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] score
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // [0] stable_jam_out, [5:1] jam_vote_total,
	                                    // [10:6] normal_vote_total, [18:11] mean_score,
	                                    // [50:19] decision_number, [55:51] zero
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int unsigned CNT_W = $clog2(MAX_GROUP + 1);
	localparam int unsigned SUM_W = SCORE_W + CNT_W;
	localparam int unsigned NUM_W = SUM_W + 1;
	localparam int unsigned DEN_W = CNT_W + 1;
	localparam int unsigned CMP_W = (CNT_W > VMIN_W) ? CNT_W : VMIN_W;

	vghd_state_t state_q, state_nxt;

	logic [THR_W-1:0]    thr_q;
	logic [SIZE_W-1:0]   size_q;
	logic [VMIN_W-1:0]   vmin_q;
	logic [SWITCH_W-1:0] switch_q;

	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    votes_q;
	logic [SUM_W-1:0]    sum_q;
	logic                stable_q;
	logic                target_q;
	logic [SWITCH_W-1:0] streak_q;
	logic [DEC_W-1:0]    dec_q;

	logic [CNT_W-1:0] votes_fin_q;
	logic [CNT_W-1:0] normal_fin_q;
	logic             cand_q;

	logic             m_valid_q;
	logic [OUT_W-1:0] m_data_q;

	logic [CNT_W-1:0] eff_size;
	logic             accept;
	logic             hit;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] votes_inc;
	logic [SUM_W-1:0] sum_inc;
	logic             close;
	logic             div_start;
	logic             div_done;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [NUM_W-1:0] div_quo;
	logic             out_load;

	logic                stable_nxt;
	logic                target_nxt;
	logic [SWITCH_W-1:0] streak_nxt;
	logic [MEAN_W-1:0]   mean_sat;
	logic [CMP_W-1:0]    votes_ext;
	logic [CMP_W-1:0]    normal_ext;

	always_comb begin
		if (size_q == '0) begin
			eff_size = CNT_W'(1);
		end else if (32'(size_q) > 32'(MAX_GROUP)) begin
			eff_size = CNT_W'(MAX_GROUP);
		end else begin
			eff_size = CNT_W'(size_q);
		end
	end

	assign accept    = s_tvalid && s_tready;
	assign hit       = s_tdata[SCORE_W-1:0] >= thr_q;
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign votes_inc = votes_q + CNT_W'(hit);
	assign sum_inc   = sum_q + SUM_W'(s_tdata[SCORE_W-1:0]);
	assign close     = cnt_inc >= eff_size;
	assign div_num   = {sum_inc, 1'b0} + NUM_W'(eff_size);
	assign div_den   = {eff_size, 1'b0};

	vghd_div #(
		.N_W (NUM_W),
		.D_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && close) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!m_valid_q || m_tready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				div_start = s_tvalid && close;
			end
			ST_DIV: begin
			end
			ST_FIN: begin
				out_load = !m_valid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stable_nxt = stable_q;
		target_nxt = target_q;
		streak_nxt = streak_q;
		if (cand_q == stable_q) begin
			streak_nxt = '0;
			target_nxt = stable_q;
		end else begin
			if (target_q != cand_q) begin
				target_nxt = cand_q;
				streak_nxt = SWITCH_W'(1);
			end else if (streak_q < STREAK_MAX) begin
				streak_nxt = streak_q + SWITCH_W'(1);
			end
			if (streak_nxt >= switch_q) begin
				stable_nxt = cand_q;
				streak_nxt = '0;
			end
		end
	end

	assign mean_sat   = (div_quo > NUM_W'(MEAN_MAX)) ? MEAN_MAX : div_quo[MEAN_W-1:0];
	assign votes_ext  = CMP_W'(votes_fin_q);
	assign normal_ext = CMP_W'(normal_fin_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			thr_q     <= RST_JAM_THRESHOLD;
			size_q    <= RST_GROUP_SIZE;
			vmin_q    <= RST_JAM_VOTE_MINIMUM;
			switch_q  <= RST_SWITCH_GROUPS;
			cnt_q     <= '0;
			votes_q   <= '0;
			sum_q     <= '0;
			stable_q  <= 1'b0;
			target_q  <= 1'b0;
			streak_q  <= '0;
			dec_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid) begin
				case (vghd_cfg_idx_t'(cfg_index))
					CFG_JAM_THRESHOLD:    thr_q    <= cfg_data[THR_W-1:0];
					CFG_GROUP_SIZE:       size_q   <= cfg_data[SIZE_W-1:0];
					CFG_JAM_VOTE_MINIMUM: vmin_q   <= cfg_data[VMIN_W-1:0];
					CFG_SWITCH_GROUPS:    switch_q <= cfg_data[SWITCH_W-1:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				if (close) begin
					cnt_q   <= '0;
					votes_q <= '0;
					sum_q   <= '0;
				end else begin
					cnt_q   <= cnt_inc;
					votes_q <= votes_inc;
					sum_q   <= sum_inc;
				end
			end
			if (out_load) begin
				stable_q  <= stable_nxt;
				target_q  <= target_nxt;
				streak_q  <= streak_nxt;
				dec_q     <= dec_q + DEC_W'(1);
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			votes_fin_q  <= votes_inc;
			normal_fin_q <= (votes_inc >= eff_size) ? '0 : eff_size - votes_inc;
			cand_q       <= CMP_W'(votes_inc) >= CMP_W'(vmin_q);
		end
		if (out_load) begin
			m_data_q <= {
				(OUT_W - DEC_W - MEAN_W - 2*VOTE_W - 1)'(0),
				dec_q + DEC_W'(1),
				mean_sat,
				normal_ext[VOTE_W-1:0],
				votes_ext[VOTE_W-1:0],
				stable_nxt
			};
		end
	end

	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign cfg_ready = 1'b1;

	`VGHD_ASSERT_NOW(a_done_in_div, div_done, state_q == ST_DIV,
		"divider finished outside the divide state")
	`VGHD_ASSERT_NEXT(a_dec_step, out_load, dec_q == $past(dec_q) + DEC_W'(1),
		"decision counter did not advance on a decision")
	`VGHD_ASSERT_NEXT(a_stable_hold, !out_load, $stable(stable_q),
		"stable state changed without a decision")

endmodule

// File: rtl/core/vghd_div.sv
module vghd_div import vghd_pkg::*; #(
	parameter int unsigned N_W = 14,
	parameter int unsigned D_W = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           done,
	output logic [N_W-1:0] quo
);

	localparam int unsigned STEP_W = $clog2(N_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [D_W-1:0]    rem_q;
	logic [D_W-1:0]    den_q;
	logic [N_W-1:0]    quo_q;

	logic [D_W:0] shifted;
	logic [D_W:0] diff;
	logic         ge;

	assign shifted = {rem_q, quo_q[N_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(N_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: dv/vote_group_hysteresis_detector_tb.sv
`timescale 1ns / 100ps

module vote_group_hysteresis_detector_tb import vghd_pkg::*;;

	localparam int unsigned MAX_GROUP = 16;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 400;

	typedef struct packed {
		logic [4:0]  pad;
		logic [31:0] decision_number;
		logic [7:0]  mean_score;
		logic [4:0]  normal_total;
		logic [4:0]  jam_total;
		logic        stable_jam;
	} decision_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = 8'd0;     // [7:0] score
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;            // [0] stable_jam_out, [5:1] jam_vote_total,
	                                      // [10:6] normal_vote_total, [18:11] mean_score,
	                                      // [50:19] decision_number, [55:51] zero
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index = 2'd0;
	logic [CFG_W-1:0] cfg_data = '0;

	// configuration as the block should hold it
	logic [THR_W-1:0]    thr_r = RST_JAM_THRESHOLD;
	logic [SIZE_W-1:0]   size_r = RST_GROUP_SIZE;
	logic [VMIN_W-1:0]   vmin_r = RST_JAM_VOTE_MINIMUM;
	logic [SWITCH_W-1:0] switch_r = RST_SWITCH_GROUPS;

	// group and hysteresis state
	logic [4:0]  group_count = '0;
	logic [4:0]  group_hits = '0;
	logic [11:0] group_sum = '0;
	logic        stable_jam = 1'b0;
	logic        pending_target = 1'b0;
	logic [3:0]  pending_streak = '0;
	logic [31:0] decision_total = '0;

	logic [7:0]  score_queue[$];
	decision_t   expected_decisions[$];

	int unsigned send_idle_pct = 10;
	int unsigned recv_idle_pct = 61;
	int unsigned mismatch_count = 0;
	int unsigned idle_cycles = 0;
	bit          hold_go = 1'b0;
	logic        hold_off = 1'b0;

	vote_group_hysteresis_detector #(.MAX_GROUP(MAX_GROUP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int unsigned eff_size();
		if (size_r == 0) return 1;
		if (size_r > MAX_GROUP) return MAX_GROUP;
		return size_r;
	endfunction

	task automatic apply_cfg(input vghd_cfg_idx_t idx, input logic [CFG_W-1:0] data);
		case (idx)
			CFG_JAM_THRESHOLD: thr_r = data[THR_W-1:0];
			CFG_GROUP_SIZE: size_r = data[SIZE_W-1:0];
			CFG_JAM_VOTE_MINIMUM: vmin_r = data[VMIN_W-1:0];
			CFG_SWITCH_GROUPS: switch_r = data[SWITCH_W-1:0];
			default: ;
		endcase
	endtask

	task automatic predict_score(input logic [7:0] score);
		int unsigned size;
		int unsigned mean;
		logic        candidate;
		decision_t   d;
		size = eff_size();
		group_count = group_count + 1'b1;
		group_sum = group_sum + score;
		if (score >= thr_r)
			group_hits = group_hits + 1'b1;
		if (group_count < size)
			return;
		mean = (2 * group_sum + size) / (2 * size);
		if (mean > MEAN_MAX)
			mean = MEAN_MAX;
		candidate = (group_hits >= vmin_r);
		if (candidate == stable_jam) begin
			pending_streak = '0;
			pending_target = stable_jam;
		end else begin
			if (pending_target != candidate) begin
				pending_target = candidate;
				pending_streak = 4'd1;
			end else if (pending_streak < STREAK_MAX) begin
				pending_streak = pending_streak + 1'b1;
			end
			if (pending_streak >= switch_r) begin
				stable_jam = candidate;
				pending_streak = '0;
			end
		end
		decision_total = decision_total + 1;
		d.pad = '0;
		d.decision_number = decision_total;
		d.mean_score = mean[7:0];
		d.normal_total = (group_hits >= size) ? 5'd0 : 5'(size - group_hits);
		d.jam_total = group_hits;
		d.stable_jam = stable_jam;
		expected_decisions.push_back(d);
		group_count = '0;
		group_hits = '0;
		group_sum = '0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_decision(input decision_t want, input decision_t got);
		check_field("pad", want.pad, got.pad);
		check_field("decision_number", want.decision_number, got.decision_number);
		check_field("mean_score", want.mean_score, got.mean_score);
		check_field("normal_vote_total", want.normal_total, got.normal_total);
		check_field("jam_vote_total", want.jam_total, got.jam_total);
		check_field("stable_jam_out", want.stable_jam, got.stable_jam);
	endtask

	// score driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'd0;
		end else begin
			if (s_tvalid && s_tready)
				predict_score(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (score_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= score_queue.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// decision monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_decisions.size() == 0) begin
					$display("%0t: decision expected none actual %h", $time, m_tdata);
					mismatch_count++;
				end else begin
					check_decision(expected_decisions.pop_front(), m_tdata);
				end
			end
			m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("FAIL vote_group_hysteresis_detector");
				$finish;
			end
		end
	end

	// stall the output long enough for the input to back up
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic write_reg(input vghd_cfg_idx_t idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_cfg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_scores(input logic [7:0] score, input int unsigned count);
		repeat (count) score_queue.push_back(score);
	endtask

	task automatic drain();
		while (score_queue.size() != 0 || s_tvalid || expected_decisions.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_score(input int unsigned bias);
		int unsigned r;
		int          n;
		r = $urandom_range(99);
		if (bias == 0 || r < 10)
			return 8'($urandom_range(255));
		if (r < 25) begin
			n = int'(thr_r) + int'($urandom_range(4)) - 2;
			if (n < 0) n = 0;
			if (n > 255) n = 255;
			return 8'(n);
		end
		if ((bias == 1) == (r < 85))
			return 8'($urandom_range(255, thr_r));
		return (thr_r == 0) ? 8'd0 : 8'($urandom_range(thr_r - 1, 0));
	endfunction

	task automatic queue_random(input int unsigned n);
		int unsigned bias;
		int unsigned groups;
		int unsigned size;
		size = eff_size();
		while (n > 0) begin
			bias = $urandom_range(2);
			groups = $urandom_range(switch_r + 2, 1);
			for (int unsigned i = 0; i < groups * size && n > 0; i++) begin
				score_queue.push_back(pick_score(bias));
				n--;
			end
		end
	endtask

	task automatic random_config();
		int unsigned r;
		int unsigned v;
		int unsigned size;
		r = $urandom_range(99);
		v = (r < 15) ? 0 : (r < 30) ? 255 : $urandom_range(255);
		write_reg(CFG_JAM_THRESHOLD, 8'(v));
		r = $urandom_range(99);
		v = (r < 10) ? 16 : (r < 15) ? 0 : (r < 20) ? $urandom_range(31, 17) : $urandom_range(8, 1);
		write_reg(CFG_GROUP_SIZE, {3'($urandom), 5'(v)});
		size = (v == 0) ? 1 : (v > MAX_GROUP) ? MAX_GROUP : v;
		r = $urandom_range(99);
		v = (r < 10) ? 0 : (r < 15) ? 31 : $urandom_range(size + 1, 0);
		write_reg(CFG_JAM_VOTE_MINIMUM, {3'($urandom), 5'(v)});
		r = $urandom_range(99);
		v = (r < 10) ? 0 : (r < 15) ? 15 : $urandom_range(4, 1);
		write_reg(CFG_SWITCH_GROUPS, {4'($urandom), 4'(v)});
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		queue_scores(8'd255, 5);
		queue_scores(8'd223, 5);
		queue_scores(8'd222, 5);
		drain();
		write_reg(CFG_JAM_THRESHOLD, 8'd0);
		write_reg(CFG_GROUP_SIZE, 8'd16);
		write_reg(CFG_JAM_VOTE_MINIMUM, 8'd0);
		write_reg(CFG_SWITCH_GROUPS, 8'd0);
		@(negedge clk);
		queue_scores(8'd255, 10);
		drain();
		// shrink the group under a partial one
		write_reg(CFG_GROUP_SIZE, 8'd2);
		@(negedge clk);
		queue_scores(8'd255, 1);
		drain();
		write_reg(CFG_GROUP_SIZE, 8'd0);
		write_reg(CFG_JAM_VOTE_MINIMUM, 8'hFF);
		write_reg(CFG_SWITCH_GROUPS, 8'hFF);
		@(negedge clk);
		queue_scores(8'd0, 1);
		queue_scores(8'd128, 1);
		queue_scores(8'd255, 1);
		drain();
		for (int unsigned phase_i = 0; phase_i < 3; phase_i++) begin
			send_idle_pct = (phase_i == 0) ? 10 : (phase_i == 1) ? 61 : 0;
			recv_idle_pct = (phase_i == 0) ? 61 : (phase_i == 1) ? 10 : 0;
			for (int unsigned seg = 0; seg < 6; seg++) begin
				random_config();
				@(negedge clk);
				queue_random(95);
				if (phase_i == 2 && seg == 0)
					hold_go = 1'b1;
				drain();
			end
		end
		if (mismatch_count == 0 && expected_decisions.size() == 0)
			$display("PASS vote_group_hysteresis_detector");
		else
			$display("FAIL vote_group_hysteresis_detector");
		$finish;
	end

endmodule
